// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int IDX_W    = CELL_AW + 1;

    // field widths
    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // blank cell and colour reset
    localparam logic [CHAR_W-1:0]  BLANK_CHAR = 8'h00;
    localparam logic [CHAR_W-1:0]  BLANK_ATTR = 8'h07;
    localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETCUR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_BS,
        OP_NL,
        OP_CR,
        OP_TAB,
        OP_SETCUR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [CELL_AW-1:0] idx;
    } t_cmd;

    function automatic logic [CELL_AW-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
        logic [IDX_W-1:0] sum;
        sum = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
        return sum[CELL_AW-1:0];
    endfunction

endpackage

// ----- rtl/tcw_front.sv -----
module tcw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic                          i_hold,
    output logic                          o_push,
    input  logic                          i_push_ready,
    output tcw_pkg::t_cmd                 o_cmd
);
    import tcw_pkg::*;

    logic [MODE_W-1:0] w_mode;
    logic [CHAR_W-1:0] w_ch;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_ccol;
    logic [ROW_W-1:0]  w_crow;
    t_cmd              w_cmd;
    logic              w_accept;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;

    assign w_mode = i_tdata[1:0];
    assign w_ch   = i_tdata[9:2];
    assign w_col  = i_tdata[16:10];
    assign w_row  = i_tdata[21:17];

    assign w_ccol = (w_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : w_col;
    assign w_crow = (w_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : w_row;

    always_comb begin
        w_cmd.ch  = w_ch;
        w_cmd.col = w_ccol;
        w_cmd.row = w_crow;
        w_cmd.idx = cell_index(w_crow, w_ccol);
        unique case (w_mode)
            MODE_PUT: begin
                unique case (w_ch)
                    CH_BS:   w_cmd.op = OP_BS;
                    CH_TAB:  w_cmd.op = OP_TAB;
                    CH_LF:   w_cmd.op = OP_NL;
                    CH_CR:   w_cmd.op = OP_CR;
                    default: w_cmd.op = OP_PUT;
                endcase
            end
            MODE_SETCUR: w_cmd.op = OP_SETCUR;
            MODE_READ:   w_cmd.op = OP_READ;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    assign o_tready = !i_hold && (!r_valid || i_push_ready);
    assign w_accept = i_tvalid && o_tready;
    assign o_push   = r_valid;
    assign o_cmd    = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

// ----- rtl/tcw_queue.sv -----
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wp;
    logic [Q_AW-1:0]   n_rp;
    logic [Q_AW:0]     n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
        end
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + (Q_AW + 1)'(1);
            2'b01:   n_cnt = r_cnt - (Q_AW + 1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/tcw_back.sv -----
module tcw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  tcw_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_cfg_data,
    output logic                          o_clearing,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_RUN,
        S_READ,
        S_SCROLL,
        S_PUT
    } t_state;

    // screen store, char and attribute planes
    logic [CHAR_W-1:0] mem_char [CELLS];
    logic [CHAR_W-1:0] mem_attr [CELLS];
    logic [CHAR_W-1:0] r_rd_char;
    logic [CHAR_W-1:0] r_rd_attr;

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [CELL_AW-1:0] r_scan, n_scan;
    logic               r_put_pend, n_put_pend;
    logic [CHAR_W-1:0]  r_ch, n_ch;
    logic [COLOR_W-1:0] r_fg, r_bg;

    logic               r_out_valid, n_out_valid;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [CHAR_W-1:0]  r_out_rc, n_out_rc;
    logic [CHAR_W-1:0]  r_out_ra, n_out_ra;
    logic               r_out_sc, n_out_sc;

    logic               w_out_free;
    logic [CELL_AW-1:0] w_rd_addr;
    logic [CELL_AW-1:0] w_wr_addr;
    logic               w_we_char;
    logic               w_we_attr;
    logic [CHAR_W-1:0]  w_wr_char;
    logic [CHAR_W-1:0]  w_wr_attr;

    logic               w_emit;
    logic [COL_W-1:0]   w_e_col;
    logic [ROW_W-1:0]   w_e_row;
    logic [CHAR_W-1:0]  w_e_rc;
    logic [CHAR_W-1:0]  w_e_ra;
    logic               w_e_sc;

    // cursor moves
    logic [COL_W-1:0]   w_bs_col;
    logic [ROW_W-1:0]   w_bs_row;
    logic [CHAR_W-1:0]  w_tab_sum;
    logic [CHAR_W-1:0]  w_tab_col;
    logic [COL_W-1:0]   w_mv_col;
    logic [ROW_W-1:0]   w_mv_row;
    logic [COL_W-1:0]   w_adv_col;
    logic [ROW_W-1:0]   w_adv_row;
    logic               w_put_on;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_sc, r_out_ra, r_out_rc, r_out_row, r_out_col};

    always_comb begin
        w_bs_col = r_col;
        w_bs_row = r_row;
        if (r_col != '0) begin
            w_bs_col = r_col - COL_W'(1);
        end else if (r_row != '0) begin
            w_bs_row = r_row - ROW_W'(1);
            w_bs_col = COL_W'(COLUMNS - 1);
        end
    end

    assign w_tab_sum = {1'b0, r_col} + CHAR_W'(TAB_STOP);
    assign w_tab_col = w_tab_sum - (w_tab_sum % CHAR_W'(TAB_STOP));

    always_comb begin
        if (i_cmd.op == OP_NL) begin
            w_mv_col = '0;
            w_mv_row = r_row + ROW_W'(1);
        end else if (w_tab_col >= CHAR_W'(COLUMNS)) begin
            w_mv_col = '0;
            w_mv_row = r_row + ROW_W'(1);
        end else begin
            w_mv_col = w_tab_col[COL_W-1:0];
            w_mv_row = r_row;
        end
    end

    assign w_put_on = (r_row < ROW_W'(ROWS)) && (r_col < COL_W'(COLUMNS));

    always_comb begin
        if (r_col + COL_W'(1) >= COL_W'(COLUMNS)) begin
            w_adv_col = '0;
            w_adv_row = r_row + ROW_W'(1);
        end else begin
            w_adv_col = r_col + COL_W'(1);
            w_adv_row = r_row;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_scan      = r_scan;
        n_put_pend  = r_put_pend;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_rc    = r_out_rc;
        n_out_ra    = r_out_ra;
        n_out_sc    = r_out_sc;
        o_pop       = 1'b0;
        w_rd_addr   = '0;
        w_wr_addr   = '0;
        w_we_char   = 1'b0;
        w_we_attr   = 1'b0;
        w_wr_char   = BLANK_CHAR;
        w_wr_attr   = BLANK_ATTR;
        w_emit      = 1'b0;
        w_e_col     = r_col;
        w_e_row     = r_row;
        w_e_rc      = '0;
        w_e_ra      = '0;
        w_e_sc      = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_addr = r_scan;
                w_we_char = 1'b1;
                w_we_attr = 1'b1;
                n_scan    = r_scan + CELL_AW'(1);
                if (r_scan == CELL_AW'(CELLS - 1)) begin
                    n_scan  = '0;
                    n_state = S_RUN;
                end
            end

            S_RUN: begin
                if (i_q_valid && w_out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CR: begin
                            n_col   = '0;
                            w_emit  = 1'b1;
                            w_e_col = '0;
                        end
                        OP_SETCUR: begin
                            n_col   = i_cmd.col;
                            n_row   = i_cmd.row;
                            w_emit  = 1'b1;
                            w_e_col = i_cmd.col;
                            w_e_row = i_cmd.row;
                        end
                        OP_NOP: begin
                            w_emit = 1'b1;
                        end
                        OP_READ: begin
                            w_rd_addr = i_cmd.idx;
                            n_state   = S_READ;
                        end
                        OP_BS: begin
                            n_col     = w_bs_col;
                            n_row     = w_bs_row;
                            w_wr_addr = cell_index(w_bs_row, w_bs_col);
                            w_wr_char = BLANK_CHAR;
                            w_we_char = (w_bs_row < ROW_W'(ROWS)) &&
                                        (w_bs_col < COL_W'(COLUMNS));
                            w_emit    = 1'b1;
                            w_e_col   = w_bs_col;
                            w_e_row   = w_bs_row;
                        end
                        OP_NL, OP_TAB: begin
                            n_col = w_mv_col;
                            if (w_mv_row > ROW_W'(ROWS - 1)) begin
                                n_row      = w_mv_row - ROW_W'(1);
                                n_put_pend = 1'b0;
                                n_scan     = '0;
                                n_state    = S_SCROLL;
                            end else begin
                                n_row   = w_mv_row;
                                w_emit  = 1'b1;
                                w_e_col = w_mv_col;
                                w_e_row = w_mv_row;
                            end
                        end
                        default: begin
                            if (r_row > ROW_W'(ROWS - 1)) begin
                                n_row      = r_row - ROW_W'(1);
                                n_ch       = i_cmd.ch;
                                n_put_pend = 1'b1;
                                n_scan     = '0;
                                n_state    = S_SCROLL;
                            end else begin
                                w_wr_addr = cell_index(r_row, r_col);
                                w_wr_char = i_cmd.ch;
                                w_wr_attr = {r_bg, r_fg};
                                w_we_char = w_put_on;
                                w_we_attr = w_put_on;
                                n_col     = w_adv_col;
                                n_row     = w_adv_row;
                                w_emit    = 1'b1;
                                w_e_col   = w_adv_col;
                                w_e_row   = w_adv_row;
                            end
                        end
                    endcase
                end
            end

            S_READ: begin
                w_emit  = 1'b1;
                w_e_rc  = r_rd_char;
                w_e_ra  = r_rd_attr;
                n_state = S_RUN;
            end

            S_SCROLL: begin
                // read runs one row ahead, write stores the registered read data in the next cycle
                if (r_scan < CELL_AW'(CELLS - COLUMNS)) begin
                    w_rd_addr = r_scan + CELL_AW'(COLUMNS);
                end
                if (r_scan != '0) begin
                    w_wr_addr = r_scan - CELL_AW'(1);
                    w_we_char = 1'b1;
                    w_we_attr = 1'b1;
                    if (r_scan <= CELL_AW'(CELLS - COLUMNS)) begin
                        w_wr_char = r_rd_char;
                        w_wr_attr = r_rd_attr;
                    end
                end
                n_scan = r_scan + CELL_AW'(1);
                if (r_scan == CELL_AW'(CELLS)) begin
                    n_scan = '0;
                    if (r_put_pend) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_RUN;
                        w_emit  = 1'b1;
                        w_e_sc  = 1'b1;
                    end
                end
            end

            S_PUT: begin
                w_wr_addr  = cell_index(r_row, r_col);
                w_wr_char  = r_ch;
                w_wr_attr  = {r_bg, r_fg};
                w_we_char  = w_put_on;
                w_we_attr  = w_put_on;
                n_col      = w_adv_col;
                n_row      = w_adv_row;
                n_put_pend = 1'b0;
                w_emit     = 1'b1;
                w_e_col    = w_adv_col;
                w_e_row    = w_adv_row;
                w_e_sc     = 1'b1;
                n_state    = S_RUN;
            end

            default: begin
                n_state = S_RUN;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_col   = w_e_col;
            n_out_row   = w_e_row;
            n_out_rc    = w_e_rc;
            n_out_ra    = w_e_ra;
            n_out_sc    = w_e_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_char) begin
            mem_char[w_wr_addr] <= w_wr_char;
        end
        if (w_we_attr) begin
            mem_attr[w_wr_addr] <= w_wr_attr;
        end
        r_rd_char <= mem_char[w_rd_addr];
        r_rd_attr <= mem_attr[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_scan      <= '0;
            r_put_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_scan      <= n_scan;
            r_put_pend  <= n_put_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FG:  r_fg <= i_cfg_data;
                    CFG_BG:  r_bg <= i_cfg_data;
                    default: r_fg <= r_fg;
                endcase
            end
        end
        r_ch      <= n_ch;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
        r_out_rc  <= n_out_rc;
        r_out_ra  <= n_out_ra;
        r_out_sc  <= n_out_sc;
    end

endmodule

// ----- rtl/text_console_char_writer.sv -----
// Cursor, return, backspace and printable items pass the front register, the queue and the
// output register; a read also passes S_READ. Throughput 1 item per cycle for these while the
// output is free and no scroll runs. A scroll walks the 2000-cell store through its single
// read and write port. Reset (synchronous, active low) starts a clearing pass of the store;
// no item is taken until it ends. Colour registers may be written meanwhile.
module text_console_char_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // mode[1:0], char_code[9:2], column[16:10], row[21:17], zero[23:22]
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], read_char[19:12], read_attr[27:20],
    // scrolled[28], zero[31:29]
    output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_cfg_data
);
    import tcw_pkg::*;

    logic w_push;
    logic w_push_ready;
    t_cmd w_front_cmd;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_q_cmd;
    logic w_clearing;

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_hold       (w_clearing),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_push_ready),
        .i_cmd   (w_front_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    tcw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_pop      (w_pop),
        .i_cmd      (w_q_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_clearing (w_clearing),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    a_no_take_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_clearing |-> !s_axis_tready
    ) else $error("item taken during clearing pass");

    a_col_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] < COL_W'(COLUMNS))
    ) else $error("cursor column out of range");

    a_row_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:7] <= ROW_W'(ROWS))
    ) else $error("cursor row out of range");

    a_scroll_row: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[28]) |->
            (m_axis_tdata[11:7] == ROW_W'(ROWS - 1) || m_axis_tdata[11:7] == ROW_W'(ROWS))
    ) else $error("scroll reported away from the bottom row");

endmodule

// ----- sim/tcw_console_checker.sv -----
`timescale 1ns / 100ps

module tcw_console_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_cfg_data,
    output int                            o_pending,
    output int                            o_errors
);
    import tcw_pkg::*;

    // same bit order as m_axis_tdata[28:0]
    typedef struct packed {
        logic              scrolled;
        logic [CHAR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_console_status;

    logic [15:0]      screen [CELLS];
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    t_console_status  status_due [$];
    int               errors = 0;

    function automatic void console_reset();
        for (int i = 0; i < CELLS; i++) screen[i] = {BLANK_ATTR, BLANK_CHAR};
        cur_col = '0;
        cur_row = '0;
        fg      = FG_RESET;
        bg      = BG_RESET;
        status_due.delete();
    endfunction

    function automatic bit cursor_visible();
        return int'(cur_col) < COLUMNS && int'(cur_row) < ROWS;
    endfunction

    function automatic int cursor_cell();
        return int'(cur_row) * COLUMNS + int'(cur_col);
    endfunction

    // a row below the screen moves everything up one row
    function automatic logic scroll_up();
        if (int'(cur_row) <= ROWS - 1) return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {BLANK_ATTR, BLANK_CHAR};
        cur_row = cur_row - 1'b1;
        return 1'b1;
    endfunction

    function automatic logic put_char(input logic [CHAR_W-1:0] ch);
        logic sc;
        int   stop;
        sc = 1'b0;
        case (ch)
            CH_CR: begin
                cur_col = '0;
            end
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col = cur_col - 1'b1;
                end else if (cur_row > 0) begin
                    cur_row = cur_row - 1'b1;
                    cur_col = COL_W'(COLUMNS - 1);
                end
                if (cursor_visible()) screen[cursor_cell()][7:0] = 8'h00;
            end
            CH_LF: begin
                cur_row = cur_row + 1'b1;
                cur_col = '0;
                sc = scroll_up();
            end
            CH_TAB: begin
                stop = (int'(cur_col) / TAB_STOP + 1) * TAB_STOP;
                cur_col = COL_W'(stop);
                if (stop >= COLUMNS) begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
                sc = scroll_up();
            end
            default: begin
                sc = scroll_up();
                if (cursor_visible()) screen[cursor_cell()] = {bg, fg, ch};
                cur_col = cur_col + 1'b1;
                if (int'(cur_col) >= COLUMNS) begin
                    cur_col = '0;
                    cur_row = cur_row + 1'b1;
                end
            end
        endcase
        return sc;
    endfunction

    function automatic void console_step(input logic [S_TDATA_W-1:0] d);
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        int                idx;
        t_console_status   st;
        mode = d[1:0];
        col  = int'(d[16:10]) > COLUMNS - 1 ? COL_W'(COLUMNS - 1) : d[16:10];
        row  = int'(d[21:17]) > ROWS - 1 ? ROW_W'(ROWS - 1) : d[21:17];
        st   = '0;
        case (mode)
            MODE_PUT: st.scrolled = put_char(d[9:2]);
            MODE_SETCUR: begin
                cur_col = col;
                cur_row = row;
            end
            MODE_READ: begin
                idx     = int'(row) * COLUMNS + int'(col);
                st.chr  = screen[idx][7:0];
                st.attr = screen[idx][15:8];
            end
            default: ;
        endcase
        st.col = cur_col;
        st.row = cur_row;
        status_due.push_back(st);
    endfunction

    function automatic void flag_mismatch(input string field, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function automatic void check_status(input logic [M_TDATA_W-1:0] d);
        t_console_status want;
        t_console_status got;
        if (status_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: unexpected result %h", $time, d);
            return;
        end
        want = status_due.pop_front();
        got  = d[$bits(t_console_status)-1:0];
        if (got.col != want.col) flag_mismatch("cursor_column", want.col, got.col);
        if (got.row != want.row) flag_mismatch("cursor_row", want.row, got.row);
        if (got.chr != want.chr) flag_mismatch("read_char", want.chr, got.chr);
        if (got.attr != want.attr) flag_mismatch("read_attr", want.attr, got.attr);
        if (got.scrolled != want.scrolled) flag_mismatch("scrolled", want.scrolled, got.scrolled);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            console_reset();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FG: fg = i_cfg_data;
                    CFG_BG: bg = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) check_status(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) console_step(s_axis_tdata);
        end
        o_pending = status_due.size();
        o_errors  = errors;
    end

endmodule

// ----- sim/tb_text_console_char_writer.sv -----
`timescale 1ns / 100ps

module tb_text_console_char_writer;
    import tcw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [COLOR_W-1:0]   i_cfg_data    = '0;

    int          pending;
    int          errors;
    bit          calm   = 1'b0;
    int unsigned cycles = 0;

    text_console_char_writer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    tcw_console_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_text_console_char_writer: errors");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] item_word(input logic [MODE_W-1:0] mode,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [COL_W-1:0]  col,
                                                      input logic [ROW_W-1:0]  row);
        return S_TDATA_W'({row, col, ch, mode});
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_item();
        int unsigned       pick;
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        pick = $urandom_range(99);
        mode = MODE_PUT;
        ch   = CHAR_W'($urandom_range(255));
        col  = COL_W'($urandom_range(127));
        row  = ROW_W'($urandom_range(31));
        if (pick < 7) begin
            ch = CH_LF;
        end else if (pick < 11) begin
            ch = CH_CR;
        end else if (pick < 15) begin
            ch = CH_TAB;
        end else if (pick < 20) begin
            ch = CH_BS;
        end else if (pick < 42) begin
            mode = pick < 30 ? MODE_SETCUR : MODE_READ;
            // mostly on screen, sometimes clamped
            if ($urandom_range(3) != 0) begin
                col = COL_W'($urandom_range(COLUMNS - 1));
                row = ROW_W'($urandom_range(ROWS - 1));
            end
        end else if (pick < 45) begin
            mode = MODE_IDLE;
        end
        return item_word(mode, ch, col, row);
    endfunction

    task automatic send_item(input logic [S_TDATA_W-1:0] d);
        if (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FG;
        i_cfg_data <= fg;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BG;
        i_cfg_data <= bg;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_colours(4'hE, 4'h1);

        send_item(item_word(MODE_PUT, 8'h41, '0, '0));
        send_item(item_word(MODE_PUT, 8'h00, '1, '1));
        send_item(item_word(MODE_PUT, 8'hFF, '0, '0));
        send_item(item_word(MODE_READ, 8'hFF, 7'd0, 5'd0));
        send_item(item_word(MODE_READ, 8'h00, '1, '1));
        send_item(item_word(MODE_PUT, CH_BS, '0, '0));
        send_item(item_word(MODE_SETCUR, 8'h00, 7'd0, 5'd0));
        send_item(item_word(MODE_PUT, CH_BS, '0, '0));
        send_item(item_word(MODE_SETCUR, 8'h00, 7'd0, 5'd5));
        send_item(item_word(MODE_PUT, CH_BS, '0, '0));
        send_item(item_word(MODE_SETCUR, 8'h00, 7'd5, 5'd0));
        send_item(item_word(MODE_PUT, CH_TAB, '0, '0));
        send_item(item_word(MODE_SETCUR, 8'h00, 7'd75, 5'd3));
        send_item(item_word(MODE_PUT, CH_TAB, '0, '0));
        // tab off the last column of the last row scrolls
        send_item(item_word(MODE_SETCUR, 8'h00, '1, '1));
        send_item(item_word(MODE_PUT, CH_TAB, '0, '0));
        send_item(item_word(MODE_SETCUR, 8'h00, 7'd79, 5'd24));
        send_item(item_word(MODE_PUT, 8'h5A, '0, '0));
        send_item(item_word(MODE_PUT, CH_LF, '0, '0));
        send_item(item_word(MODE_PUT, CH_CR, '0, '0));
        send_item(item_word(MODE_PUT, CH_BS, '0, '0));
        send_item(item_word(MODE_PUT, CH_LF, '0, '0));
        send_item(item_word(MODE_PUT, 8'h79, '0, '0));
        send_item(item_word(MODE_PUT, CH_LF, '0, '0));
        send_item(item_word(MODE_READ, 8'h00, 7'd0, 5'd23));
        send_item(item_word(MODE_IDLE, 8'hFF, '1, '1));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_colours(4'h0, 4'h0);
                1: set_colours(4'hF, 4'hF);
                2: set_colours(4'h0, 4'hF);
                3: set_colours(4'hF, 4'h0);
                default: set_colours(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
            endcase
            calm <= (ph == 2);
            repeat (170) send_item(random_item());
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_text_console_char_writer: clean");
        end else begin
            $display("tb_text_console_char_writer: errors");
        end
        $finish;
    end

endmodule

// ----- text_console_char_writer.f -----
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_char_writer.sv
sim/tcw_console_checker.sv
sim/tb_text_console_char_writer.sv
